// File: rtl/core/bcc_pkg.sv
// Shared types and constants for the button click classifier.
package bcc_pkg;

    // Configuration port address width: six 32-bit registers at 4-byte spacing
    localparam int ADDR_W = 5;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_POLARITY_LOW = 3'd0,
        REG_REPEAT_ON    = 3'd1,
        REG_DEBOUNCE_MS  = 3'd2,
        REG_LONG_MS      = 3'd3,
        REG_DOUBLE_MS    = 3'd4,
        REG_REPEAT_MS    = 3'd5
    } t_reg_idx;

    // Event kinds reported on the result channel
    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_LONG   = 2'd1,
        KIND_DOUBLE = 2'd2
    } t_kind;

    // Reset values of the configuration registers
    localparam logic        RST_POLARITY_LOW = 1'b1;
    localparam logic        RST_REPEAT_ON    = 1'b0;
    localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd50;
    localparam logic [15:0] RST_LONG_MS      = 16'd1000;
    localparam logic [15:0] RST_DOUBLE_MS    = 16'd300;
    localparam logic [15:0] RST_REPEAT_MS    = 16'd200;

    // Configuration bundle from the register file to the classifier
    typedef struct packed {
        logic        polarity_low;
        logic        repeat_on;
        logic [15:0] debounce_ms;
        logic [15:0] long_ms;
        logic [15:0] double_ms;
        logic [15:0] repeat_ms;
    } t_cfg;

    // One classified sample
    typedef struct packed {
        logic  event_valid;
        t_kind kind;
        logic  pressed;
    } t_result;

endpackage

// File: rtl/core/bcc_regs.sv
// APB-style configuration register file for the button click classifier.
module bcc_regs
    import bcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polarity_low <= RST_POLARITY_LOW;
            r_cfg.repeat_on    <= RST_REPEAT_ON;
            r_cfg.debounce_ms  <= RST_DEBOUNCE_MS;
            r_cfg.long_ms      <= RST_LONG_MS;
            r_cfg.double_ms    <= RST_DOUBLE_MS;
            r_cfg.repeat_ms    <= RST_REPEAT_MS;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POLARITY_LOW: r_cfg.polarity_low <= pwdata[0];
                REG_REPEAT_ON:    r_cfg.repeat_on    <= pwdata[0];
                REG_DEBOUNCE_MS:  r_cfg.debounce_ms  <= pwdata[15:0];
                REG_LONG_MS:      r_cfg.long_ms      <= pwdata[15:0];
                REG_DOUBLE_MS:    r_cfg.double_ms    <= pwdata[15:0];
                REG_REPEAT_MS:    r_cfg.repeat_ms    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_POLARITY_LOW: prdata = {31'd0, r_cfg.polarity_low};
            REG_REPEAT_ON:    prdata = {31'd0, r_cfg.repeat_on};
            REG_DEBOUNCE_MS:  prdata = {16'd0, r_cfg.debounce_ms};
            REG_LONG_MS:      prdata = {16'd0, r_cfg.long_ms};
            REG_DOUBLE_MS:    prdata = {16'd0, r_cfg.double_ms};
            REG_REPEAT_MS:    prdata = {16'd0, r_cfg.repeat_ms};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/bcc_core.sv
// Debounce and click classification state with its single-pass update logic.
module bcc_core
    import bcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_pin_level,
    input  logic [31:0] i_now_ms,
    input  t_cfg        i_cfg,
    output t_result     o_res
);

    // Classifier state
    logic        r_stable_level;
    logic [31:0] r_change_time;
    logic [31:0] r_press_start;
    logic [31:0] r_repeat_time;
    logic        r_long_fired;
    logic [31:0] r_release_time;
    logic        r_awaiting;

    logic        n_stable_level;
    logic [31:0] n_change_time;
    logic [31:0] n_press_start;
    logic [31:0] n_repeat_time;
    logic        n_long_fired;
    logic [31:0] n_release_time;
    logic        n_awaiting;

    logic        w_pressed;
    logic        w_ev_valid;
    t_kind       w_kind;

    // Sample update: debounced edge, then long press, then double-click timeout
    always_comb begin
        logic [31:0] since_change;
        logic [31:0] held;
        logic [31:0] since_release;
        logic [31:0] since_press;
        logic [31:0] since_repeat;
        logic [31:0] since_release2;

        n_stable_level = r_stable_level;
        n_change_time  = r_change_time;
        n_press_start  = r_press_start;
        n_repeat_time  = r_repeat_time;
        n_long_fired   = r_long_fired;
        n_release_time = r_release_time;
        n_awaiting     = r_awaiting;
        w_ev_valid     = 1'b0;
        w_kind         = KIND_SHORT;

        w_pressed = i_cfg.polarity_low ? !i_pin_level : i_pin_level;

        // accepted level change
        since_change  = i_now_ms - r_change_time;
        held          = i_now_ms - r_press_start;
        since_release = i_now_ms - r_release_time;
        if (w_pressed != r_stable_level && since_change > {16'd0, i_cfg.debounce_ms}) begin
            n_change_time  = i_now_ms;
            n_stable_level = w_pressed;
            if (w_pressed) begin
                n_press_start = i_now_ms;
                n_long_fired  = 1'b0;
            end else begin
                if (!r_long_fired && held < {16'd0, i_cfg.long_ms}) begin
                    if (r_awaiting && since_release < {16'd0, i_cfg.double_ms}) begin
                        w_ev_valid = 1'b1;
                        w_kind     = KIND_DOUBLE;
                        n_awaiting = 1'b0;
                    end else begin
                        n_awaiting     = 1'b1;
                        n_release_time = i_now_ms;
                    end
                end
                n_long_fired = 1'b0;
            end
        end

        // long press and repeats, measured on the raw sample
        since_press  = i_now_ms - n_press_start;
        since_repeat = i_now_ms - r_repeat_time;
        if (w_pressed && since_press > {16'd0, i_cfg.long_ms}) begin
            if (!n_long_fired) begin
                n_long_fired  = 1'b1;
                n_awaiting    = 1'b0;
                n_repeat_time = i_now_ms;
                w_ev_valid    = 1'b1;
                w_kind        = KIND_LONG;
            end else if (i_cfg.repeat_on && since_repeat > {16'd0, i_cfg.repeat_ms}) begin
                n_repeat_time = i_now_ms;
                w_ev_valid    = 1'b1;
                w_kind        = KIND_LONG;
            end
        end

        // double-click window ran out: single short press
        since_release2 = i_now_ms - n_release_time;
        if (n_awaiting && since_release2 > {16'd0, i_cfg.double_ms}) begin
            n_awaiting = 1'b0;
            w_ev_valid = 1'b1;
            w_kind     = KIND_SHORT;
        end
    end

    // State registers advance once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_level <= 1'b0;
            r_change_time  <= 32'd0;
            r_press_start  <= 32'd0;
            r_repeat_time  <= 32'd0;
            r_long_fired   <= 1'b0;
            r_release_time <= 32'd0;
            r_awaiting     <= 1'b0;
        end else if (i_step) begin
            r_stable_level <= n_stable_level;
            r_change_time  <= n_change_time;
            r_press_start  <= n_press_start;
            r_repeat_time  <= n_repeat_time;
            r_long_fired   <= n_long_fired;
            r_release_time <= n_release_time;
            r_awaiting     <= n_awaiting;
        end
    end

    assign o_res.event_valid = w_ev_valid;
    assign o_res.kind        = w_kind;
    assign o_res.pressed     = w_pressed;

    // A double click always closes the wait
    a_double_clears_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_ev_valid && w_kind == KIND_DOUBLE |=> !r_awaiting)
        else $error("double click left the wait open");

    // Any long or repeat event leaves the long press marked
    a_long_marks_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_ev_valid && w_kind == KIND_LONG |=> r_long_fired)
        else $error("long event without long_fired set");

    // State holds between transactions
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_awaiting) && $stable(r_long_fired) && $stable(r_press_start))
        else $error("classifier state moved without a transaction");

endmodule

// File: rtl/core/button_click_classifier_unit.sv
// Top level of the button click classifier: input register, classifier, result register.
// A sample is captured in the input register and classified as it moves into the result
// register, from which its result can be taken.
// Throughput: one sample per clock unless stalled; the classifier update is one pass between
// the input and result registers, and the result register frees itself as it is taken.
// Reset (i_rst_n low at a clock edge) empties both registers, clears the classifier
// state and loads the configuration reset values.
module button_click_classifier_unit
    import bcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_pin_level,
    input  logic [31:0]       i_now_ms,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_event_valid,
    output logic [1:0]        o_event_kind,
    output logic              o_is_pressed,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg        w_cfg;
    t_result     w_res;

    logic        r_in_valid;
    logic        r_in_level;
    logic [31:0] r_in_now;

    logic        r_out_valid;
    logic        r_out_event;
    t_kind       r_out_kind;
    logic        r_out_pressed;

    logic        w_advance;
    logic        w_accept;

    bcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bcc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_pin_level (r_in_level),
        .i_now_ms    (r_in_now),
        .i_cfg       (w_cfg),
        .o_res       (w_res)
    );

    // Pipeline flow: input register moves when the result register is free or drains
    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_level <= i_pin_level;
            r_in_now   <= i_now_ms;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_event   <= w_res.event_valid;
            r_out_kind    <= w_res.kind;
            r_out_pressed <= w_res.pressed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_valid = r_out_event;
    assign o_event_kind  = r_out_kind;
    assign o_is_pressed  = r_out_pressed;

    // Back-pressure only when a sample is actually held
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled with nothing blocking it");

    // A processed sample always lands in the result register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_valid)
        else $error("processed sample lost");

    // No event means a short-press code on the kind field
    a_idle_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_event_valid |-> o_event_kind == KIND_SHORT)
        else $error("kind set without an event");

endmodule

// File: sim/button_click_classifier_unit_test.sv
// Self-checking testbench for the button click classifier: directed table, random gestures.
`timescale 1ns / 1ps

module button_click_classifier_unit_test;
    import bcc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int N_PLAN      = 21;

    // One directed sample; chk marks rows whose result is typed in here
    typedef struct packed {
        logic        pin;
        logic [31:0] now;
        logic        chk;
        logic        ev;
        t_kind       kind;
        logic        prs;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_pin_level;
    logic [31:0]       i_now_ms;
    logic              o_valid;
    logic              i_stall;
    logic              o_event_valid;
    logic [1:0]        o_event_kind;
    logic              o_is_pressed;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Typed expectation travels with the payload so the monitor sees the right one
    logic              drv_chk;
    t_result           drv_exp;

    // Shadow configuration and classifier state
    t_cfg              cfg;
    logic              sh_stable;
    logic [31:0]       sh_change_t;
    logic [31:0]       sh_press_t;
    logic [31:0]       sh_repeat_t;
    logic              sh_long_fired;
    logic [31:0]       sh_release_t;
    logic              sh_awaiting;

    t_result           expected_events [$];
    t_result           head_exp;
    t_result           new_exp;
    t_row              plan [N_PLAN];
    logic [31:0]       now_t;

    int                cycle_cnt;
    int                n_mismatch;
    int                n_accepted;
    int                n_sent;
    int                n_checked;
    int                n_short;
    int                n_long;
    int                n_double;
    int                n_settings;
    int                stall_left;
    bit                quiet;

    button_click_classifier_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pin_level  (i_pin_level),
        .i_now_ms     (i_now_ms),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_valid(o_event_valid),
        .o_event_kind (o_event_kind),
        .o_is_pressed (o_is_pressed),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        end
    endtask

    // Classifier prediction: debounce, then release, long press, wait timeout in that order
    function automatic t_result classify_sample(input logic pin, input logic [31:0] now);
        logic        pressed;
        logic        hit;
        t_kind       kind;
        logic [31:0] held;
        t_result     r;
        pressed = cfg.polarity_low ? (pin == 1'b0) : (pin == 1'b1);
        hit     = 1'b0;
        kind    = KIND_SHORT;
        if (pressed != sh_stable && (now - sh_change_t) > cfg.debounce_ms) begin
            sh_change_t = now;
            sh_stable   = pressed;
            if (pressed) begin
                sh_press_t    = now;
                sh_long_fired = 1'b0;
            end else begin
                held = now - sh_press_t;
                if (!sh_long_fired && held < cfg.long_ms) begin
                    if (sh_awaiting && (now - sh_release_t) < cfg.double_ms) begin
                        hit         = 1'b1;
                        kind        = KIND_DOUBLE;
                        sh_awaiting = 1'b0;
                    end else begin
                        sh_awaiting  = 1'b1;
                        sh_release_t = now;
                    end
                end
                sh_long_fired = 1'b0;
            end
        end
        // long press is judged on the raw sample, not the debounced level
        if (pressed && (now - sh_press_t) > cfg.long_ms) begin
            if (!sh_long_fired) begin
                sh_long_fired = 1'b1;
                sh_awaiting   = 1'b0;
                sh_repeat_t   = now;
                hit           = 1'b1;
                kind          = KIND_LONG;
            end else if (cfg.repeat_on && (now - sh_repeat_t) > cfg.repeat_ms) begin
                sh_repeat_t = now;
                hit         = 1'b1;
                kind        = KIND_LONG;
            end
        end
        if (sh_awaiting && (now - sh_release_t) > cfg.double_ms) begin
            sh_awaiting = 1'b0;
            hit         = 1'b1;
            kind        = KIND_SHORT;
        end
        r.event_valid = hit;
        r.kind        = hit ? kind : KIND_SHORT;
        r.pressed     = pressed;
        return r;
    endfunction

    // Monitor: check taken results, predict taken samples, watch the cycle budget
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_events.size() == 0) begin
                    flag_mismatch($sformatf("result ev=%0b kind=%0d prs=%0b with nothing expected",
                                            o_event_valid, o_event_kind, o_is_pressed));
                end else begin
                    head_exp = expected_events.pop_front();
                    n_checked++;
                    if (o_event_valid !== head_exp.event_valid ||
                        o_event_kind !== head_exp.kind ||
                        o_is_pressed !== head_exp.pressed) begin
                        flag_mismatch($sformatf(
                            "exp ev=%0b kind=%0d prs=%0b, got ev=%0b kind=%0d prs=%0b",
                            head_exp.event_valid, head_exp.kind, head_exp.pressed,
                            o_event_valid, o_event_kind, o_is_pressed));
                    end
                    if (head_exp.event_valid) begin
                        case (head_exp.kind)
                            KIND_SHORT:  n_short++;
                            KIND_LONG:   n_long++;
                            KIND_DOUBLE: n_double++;
                            default: ;
                        endcase
                    end
                end
            end
            if (i_valid && !o_stall) begin
                new_exp = classify_sample(i_pin_level, i_now_ms);
                if (drv_chk) begin
                    new_exp = drv_exp;
                end
                expected_events.push_back(new_exp);
                n_accepted++;
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_events.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side backpressure in random bursts
    initial begin
        i_stall <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && i_rst_n && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Present one sample and hold it until the transaction is taken
    task automatic send_sample(input logic pin, input logic [31:0] now,
                               input logic chk, input t_result exp);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pin_level <= pin;
        i_now_ms    <= now;
        drv_chk     <= chk;
        drv_exp     <= exp;
        n_sent++;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic quiesce();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write, then read back known registers
    task automatic cfg_write(input int unsigned idx, input logic [31:0] val);
        logic [31:0] kept;
        logic        known;
        known = 1'b1;
        case (idx)
            REG_POLARITY_LOW: begin
                kept = {31'd0, val[0]};
                cfg.polarity_low = val[0];
            end
            REG_REPEAT_ON: begin
                kept = {31'd0, val[0]};
                cfg.repeat_on = val[0];
            end
            REG_DEBOUNCE_MS: begin
                kept = {16'd0, val[15:0]};
                cfg.debounce_ms = val[15:0];
            end
            REG_LONG_MS: begin
                kept = {16'd0, val[15:0]};
                cfg.long_ms = val[15:0];
            end
            REG_DOUBLE_MS: begin
                kept = {16'd0, val[15:0]};
                cfg.double_ms = val[15:0];
            end
            REG_REPEAT_MS: begin
                kept = {16'd0, val[15:0]};
                cfg.repeat_ms = val[15:0];
            end
            default: begin
                kept  = '0;
                known = 1'b0;
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (known) begin
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== kept) begin
                flag_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, kept));
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // New register setting; unused upper bits of each write carry random junk
    task automatic apply_settings(input logic pol, input logic rep, input logic [15:0] deb,
                                  input logic [15:0] lng, input logic [15:0] dbl,
                                  input logic [15:0] rpt);
        quiesce();
        cfg_write(REG_POLARITY_LOW, {31'($urandom_range(0, 32'h7FFF_FFFF)), pol});
        cfg_write(REG_REPEAT_ON,    {31'($urandom_range(0, 32'h7FFF_FFFF)), rep});
        cfg_write(REG_DEBOUNCE_MS,  {16'($urandom_range(0, 16'hFFFF)), deb});
        cfg_write(REG_LONG_MS,      {16'($urandom_range(0, 16'hFFFF)), lng});
        cfg_write(REG_DOUBLE_MS,    {16'($urandom_range(0, 16'hFFFF)), dbl});
        cfg_write(REG_REPEAT_MS,    {16'($urandom_range(0, 16'hFFFF)), rpt});
        n_settings++;
    endtask

    // Hold one intended level for about span ms over n samples, bouncing at the start
    task automatic push_level(input logic press, input int unsigned span, input int n);
        int unsigned stepv;
        logic        pin;
        stepv = span / n + 1;
        for (int k = 0; k < n; k++) begin
            pin = press ^ cfg.polarity_low;
            if (k < 2 && $urandom_range(0, 2) == 0) begin
                pin = ~pin;
            end
            now_t += $urandom_range(stepv / 2, stepv + stepv / 2);
            send_sample(pin, now_t, 1'b0, '0);
        end
    endtask

    // One user gesture: clicks, double clicks, holds, noise or a clock jump
    task automatic play_gesture();
        int          pick;
        int unsigned lg;
        int unsigned db;
        int unsigned dm;
        int unsigned rp;
        pick = $urandom_range(0, 9);
        lg   = 32'(cfg.long_ms);
        db   = 32'(cfg.debounce_ms);
        dm   = 32'(cfg.double_ms);
        rp   = 32'(cfg.repeat_ms);
        if (pick < 4) begin
            push_level(1'b1, $urandom_range(0, lg), $urandom_range(2, 5));
            push_level(1'b0, $urandom_range(0, 3 * dm + db + 4), $urandom_range(2, 5));
        end else if (pick < 6) begin
            push_level(1'b1, $urandom_range(0, lg), 3);
            push_level(1'b0, $urandom_range(0, dm), 2);
            push_level(1'b1, $urandom_range(0, lg), 3);
            push_level(1'b0, dm + db + $urandom_range(1, 200), 3);
        end else if (pick < 8) begin
            push_level(1'b1, lg + rp * $urandom_range(1, 4) + $urandom_range(1, 50),
                       $urandom_range(4, 12));
            push_level(1'b0, $urandom_range(0, 2 * dm + db + 4), $urandom_range(2, 5));
        end else if (pick == 8) begin
            repeat ($urandom_range(2, 6)) begin
                now_t += $urandom_range(0, 2 * db + 2);
                send_sample(1'($urandom_range(0, 1)), now_t, 1'b0, '0);
            end
        end else begin
            // jump anywhere, sometimes just short of the wrap
            if ($urandom_range(0, 1) == 0) begin
                now_t = $urandom;
            end else begin
                now_t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            end
            send_sample(1'($urandom_range(0, 1)), now_t, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int n_items);
        int start;
        start = n_sent;
        while (n_sent - start < n_items) play_gesture();
    endtask

    // Stimulus
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pin_level <= 1'b0;
        i_now_ms    <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        drv_chk     <= 1'b0;
        drv_exp     <= '0;
        quiet       = 1'b0;
        cycle_cnt   = 0;
        n_mismatch  = 0;
        n_accepted  = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_short     = 0;
        n_long      = 0;
        n_double    = 0;
        n_settings  = 1;
        now_t       = '0;

        // shadow model starts from the reset values
        cfg.polarity_low = RST_POLARITY_LOW;
        cfg.repeat_on    = RST_REPEAT_ON;
        cfg.debounce_ms  = RST_DEBOUNCE_MS;
        cfg.long_ms      = RST_LONG_MS;
        cfg.double_ms    = RST_DOUBLE_MS;
        cfg.repeat_ms    = RST_REPEAT_MS;
        sh_stable     = 1'b0;
        sh_change_t   = '0;
        sh_press_t    = '0;
        sh_repeat_t   = '0;
        sh_long_fired = 1'b0;
        sh_release_t  = '0;
        sh_awaiting   = 1'b0;

        // Directed samples under reset settings (pin low means pressed)
        plan = '{
            '{1'b1, 32'd0,          1'b1, 1'b0, KIND_SHORT, 1'b0}, // idle after reset
            '{1'b0, 32'd10,         1'b1, 1'b0, KIND_SHORT, 1'b1}, // bounce inside debounce
            '{1'b0, 32'd100,        1'b0, 1'b0, KIND_SHORT, 1'b0}, // press taken
            '{1'b1, 32'd200,        1'b0, 1'b0, KIND_SHORT, 1'b0}, // release, wait for second
            '{1'b0, 32'd300,        1'b0, 1'b0, KIND_SHORT, 1'b0},
            '{1'b1, 32'd400,        1'b0, 1'b0, KIND_SHORT, 1'b0}, // double click
            '{1'b1, 32'd500,        1'b0, 1'b0, KIND_SHORT, 1'b0},
            '{1'b0, 32'd600,        1'b0, 1'b0, KIND_SHORT, 1'b0},
            '{1'b1, 32'd700,        1'b0, 1'b0, KIND_SHORT, 1'b0},
            '{1'b1, 32'd1001,       1'b0, 1'b0, KIND_SHORT, 1'b0}, // wait runs out: short
            '{1'b0, 32'd2000,       1'b0, 1'b0, KIND_SHORT, 1'b0},
            '{1'b0, 32'd3001,       1'b0, 1'b0, KIND_SHORT, 1'b0}, // long press
            '{1'b0, 32'd4000,       1'b0, 1'b0, KIND_SHORT, 1'b0}, // held, repeat off
            '{1'b1, 32'd4100,       1'b0, 1'b0, KIND_SHORT, 1'b0}, // release after long
            '{1'b0, 32'd4110,       1'b0, 1'b0, KIND_SHORT, 1'b0}, // long from raw sample
            '{1'b0, 32'hFFFF_FFF0,  1'b0, 1'b0, KIND_SHORT, 1'b0}, // press near wrap
            '{1'b1, 32'h0000_0020,  1'b0, 1'b0, KIND_SHORT, 1'b0}, // bounce across wrap
            '{1'b1, 32'h0000_0030,  1'b0, 1'b0, KIND_SHORT, 1'b0},
            '{1'b1, 32'h0000_015D,  1'b0, 1'b0, KIND_SHORT, 1'b0},
            '{1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, KIND_SHORT, 1'b0}, // time extremes
            '{1'b1, 32'h0000_0000,  1'b0, 1'b0, KIND_SHORT, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_PLAN; r++) begin
            send_sample(plan[r].pin, plan[r].now, plan[r].chk,
                        '{event_valid: plan[r].ev, kind: plan[r].kind, pressed: plan[r].prs});
        end

        // Random gestures over a series of settings, extremes first
        now_t = $urandom;
        apply_settings(1'b0, 1'b1, 16'd5, 16'd100, 16'd60, 16'd20);
        run_phase(110);
        apply_settings(1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(110);
        apply_settings(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(90);
        apply_settings(1'b1, 1'b1, 16'd3, 16'hFFFF, 16'hFFFF, 16'd0);
        run_phase(90);
        // writes to unmapped indexes must change nothing
        quiesce();
        cfg_write(6, $urandom);
        cfg_write(7, $urandom);
        run_phase(40);
        repeat (3) begin
            apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           16'($urandom_range(0, 40)), 16'($urandom_range(0, 400)),
                           16'($urandom_range(0, 300)), 16'($urandom_range(0, 100)));
            run_phase(110);
        end
        // closing stretch with no idling on either side
        quiet = 1'b1;
        apply_settings(1'($urandom_range(0, 1)), 1'b1, 16'($urandom_range(0, 20)),
                       16'($urandom_range(0, 200)), 16'($urandom_range(0, 150)),
                       16'($urandom_range(0, 50)));
        run_phase(60);
        quiesce();

        if (expected_events.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", expected_events.size()));
        end
        $display("Covered %0d samples over %0d register settings, %0d results checked.",
                 n_accepted, n_settings, n_checked);
        $display("Events: %0d short, %0d long or repeat, %0d double; %0d mismatches.",
                 n_short, n_long, n_double, n_mismatch);
        if (n_mismatch == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/bcc_pkg.sv
rtl/core/bcc_regs.sv
rtl/core/bcc_core.sv
rtl/core/button_click_classifier_unit.sv
sim/button_click_classifier_unit_test.sv
